// File: rtl/mm3_pkg.sv
package mm3_pkg;

	// Mixing and finalisation constants
	localparam logic [31:0] MIX_C1   = 32'hcc9e2d51;
	localparam logic [31:0] MIX_C2   = 32'h1b873593;
	localparam logic [31:0] FOLD_ADD = 32'he6546b64;
	localparam logic [31:0] FIN_M1   = 32'h85ebca6b;
	localparam logic [31:0] FIN_M2   = 32'hc2b2ae35;

	// Bytes in a full word
	localparam logic [2:0] FULL_COUNT = 3'd4;

	// Queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Scrambled word with its normalised byte count
	typedef struct packed {
		logic [31:0] k;
		logic [2:0]  cnt;
		logic        last;
	} item_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] level;
	} q_status_t;

endpackage

// File: rtl/murmur3_32_stream_hash.sv
// MurmurHash3 (x86, 32-bit) over a key streamed as little-endian 32-bit words,
// first byte in bits 7:0. Every word but the last must carry four bytes; the
// word flagged by last_word carries zero to four, and bytes above byte_count
// are ignored. A count above four, or any word not flagged last, counts as
// four bytes. One hash_value item leaves per key, after its last word. The
// seed is loaded through hash_seed_we/hash_seed and is picked up by the first
// word of each key, so write it only between keys. Rate: one word per cycle
// sustained while hash_stall stays low. The front scrambles each word in a
// two-stage multiply pipeline, a four-entry queue decouples it from the back,
// and the back folds one queued word per cycle, unless a stalled output holds
// it, into the running hash, then finalises through the registers x_s1, y_s2
// and z_s3, ending in the output register.
// A stalled output holds the back end; the front keeps accepting until the
// queue fills.
module murmur3_32_stream_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        hash_seed_we,
	input  logic [31:0] hash_seed,
	input  logic        key_valid,
	output logic        key_stall,
	input  logic [31:0] key_word,
	input  logic [2:0]  byte_count,
	input  logic        last_word,
	output logic        hash_valid,
	input  logic        hash_stall,
	output logic [31:0] hash_value
);

	mm3_pkg::q_status_t q_status;
	mm3_pkg::item_t     push_item;
	mm3_pkg::item_t     head_item;
	logic               q_push;
	logic               q_pop;

	// Front: classify the word, mask the tail, scramble
	mm3_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_valid  (key_valid),
		.key_stall  (key_stall),
		.key_word   (key_word),
		.byte_count (byte_count),
		.last_word  (last_word),
		.q_status   (q_status),
		.q_push     (q_push),
		.q_item     (push_item)
	);

	// Queue: let front and back stall independently
	mm3_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.head_item (head_item),
		.status    (q_status)
	);

	// Back: fold into the running hash, add the length, finalise
	mm3_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.hash_seed_we (hash_seed_we),
		.hash_seed    (hash_seed),
		.q_status     (q_status),
		.head_item    (head_item),
		.q_pop        (q_pop),
		.hash_valid   (hash_valid),
		.hash_stall   (hash_stall),
		.hash_value   (hash_value)
	);

	// The front never pushes into a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_status.full))
		else $error("push into full queue");

	// The back never pops an empty queue
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_status.empty))
		else $error("pop from empty queue");

	// A push without a pop raises the occupancy by one, which stays within depth
	a_level_track: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && !q_pop) |=> (q_status.level == $past(q_status.level) + 1'b1)
		&& (q_status.level <= mm3_pkg::QCNT_W'(mm3_pkg::QDEPTH)))
		else $error("queue level mismatch");

endmodule

// File: rtl/mm3_front.sv
module mm3_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              key_valid,
	output logic              key_stall,
	input  logic [31:0]       key_word,
	input  logic [2:0]        byte_count,
	input  logic              last_word,
	input  mm3_pkg::q_status_t q_status,
	output logic              q_push,
	output mm3_pkg::item_t    q_item
);

	logic        adv;
	logic [2:0]  cnt_norm;
	logic [31:0] mask;
	logic [31:0] masked;
	logic [31:0] rot_s1;

	logic        valid_s1;
	logic [31:0] prod_s1;
	logic [2:0]  cnt_s1;
	logic        last_s1;

	logic        valid_s2;
	logic [31:0] k_s2;
	logic [2:0]  cnt_s2;
	logic        last_s2;

	// Hold the whole pipeline only when stage two cannot drain
	assign adv       = !(valid_s2 && q_status.full);
	assign key_stall = !adv;

	always_comb begin
		if (last_word && (byte_count inside {[3'd0:3'd4]})) begin
			cnt_norm = byte_count;
		end else begin
			cnt_norm = mm3_pkg::FULL_COUNT;
		end
		case (cnt_norm)
			3'd0:    mask = 32'h00000000;
			3'd1:    mask = 32'h000000ff;
			3'd2:    mask = 32'h0000ffff;
			3'd3:    mask = 32'h00ffffff;
			default: mask = 32'hffffffff;
		endcase
	end

	assign masked = key_word & mask;
	assign rot_s1 = {prod_s1[16:0], prod_s1[31:17]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= key_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= masked * mm3_pkg::MIX_C1;
			cnt_s1  <= cnt_norm;
			last_s1 <= last_word;
			k_s2    <= rot_s1 * mm3_pkg::MIX_C2;
			cnt_s2  <= cnt_s1;
			last_s2 <= last_s1;
		end
	end

	assign q_push      = valid_s2 && adv;
	assign q_item.k    = k_s2;
	assign q_item.cnt  = cnt_s2;
	assign q_item.last = last_s2;

endmodule

// File: rtl/mm3_queue.sv
module mm3_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  mm3_pkg::item_t     push_item,
	input  logic               pop,
	output mm3_pkg::item_t     head_item,
	output mm3_pkg::q_status_t status
);

	mm3_pkg::item_t                   slot_q [mm3_pkg::QDEPTH];
	logic [mm3_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [mm3_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [mm3_pkg::QCNT_W-1:0]       level_q;
	logic                             do_push;
	logic                             do_pop;

	assign status.full  = (level_q == mm3_pkg::QCNT_W'(mm3_pkg::QDEPTH));
	assign status.empty = (level_q == '0);
	assign status.level = level_q;

	// Drop requests that would overrun or underrun
	assign do_push = push && !status.full;
	assign do_pop  = pop && !status.empty;

	assign head_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == mm3_pkg::QPTR_W'(mm3_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == mm3_pkg::QPTR_W'(mm3_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: rtl/mm3_back.sv
module mm3_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               hash_seed_we,
	input  logic [31:0]        hash_seed,
	input  mm3_pkg::q_status_t q_status,
	input  mm3_pkg::item_t     head_item,
	output logic               q_pop,
	output logic               hash_valid,
	input  logic               hash_stall,
	output logic [31:0]        hash_value
);

	logic        adv;
	logic [31:0] h_base;
	logic [31:0] len_base;
	logic [31:0] h_mix;
	logic [31:0] h_rot;
	logic [31:0] h_new;
	logic [31:0] len_new;
	logic [31:0] x_mix;
	logic [31:0] y_mix;
	logic [31:0] z_mix;

	logic [31:0] seed_q;
	logic [31:0] run_q;
	logic [31:0] len_q;
	logic        key_open_q;

	logic        valid_s1;
	logic [31:0] x_s1;
	logic        valid_s2;
	logic [31:0] y_s2;
	logic        valid_s3;
	logic [31:0] z_s3;
	logic        hash_valid_q;
	logic [31:0] hash_value_q;

	assign adv   = !hash_valid_q || !hash_stall;
	assign q_pop = adv && !q_status.empty;

	// A fresh key starts from the seed with zero length
	assign h_base   = key_open_q ? run_q : seed_q;
	assign len_base = key_open_q ? len_q : 32'd0;
	assign h_mix    = (head_item.cnt != 3'd0) ? (h_base ^ head_item.k) : h_base;
	assign h_rot    = {h_mix[18:0], h_mix[31:19]};
	assign h_new    = (head_item.cnt == mm3_pkg::FULL_COUNT) ?
		({h_rot[29:0], 2'b00} + h_rot + mm3_pkg::FOLD_ADD) : h_mix;
	assign len_new  = len_base + {29'd0, head_item.cnt};

	assign x_mix = x_s1 ^ {16'd0, x_s1[31:16]};
	assign y_mix = y_s2 ^ {13'd0, y_s2[31:13]};
	assign z_mix = z_s3 ^ {16'd0, z_s3[31:16]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q       <= 32'd0;
			key_open_q   <= 1'b0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			valid_s3     <= 1'b0;
			hash_valid_q <= 1'b0;
		end else begin
			if (hash_seed_we) begin
				seed_q <= hash_seed;
			end
			if (q_pop) begin
				key_open_q <= !head_item.last;
			end
			if (adv) begin
				valid_s1     <= q_pop && head_item.last;
				valid_s2     <= valid_s1;
				valid_s3     <= valid_s2;
				hash_valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			run_q <= h_new;
			len_q <= len_new;
		end
		if (adv) begin
			x_s1         <= h_new ^ len_new;
			y_s2         <= x_mix * mm3_pkg::FIN_M1;
			z_s3         <= y_mix * mm3_pkg::FIN_M2;
			hash_value_q <= z_mix;
		end
	end

	assign hash_valid = hash_valid_q;
	assign hash_value = hash_value_q;

endmodule

// File: test/murmur3_32_stream_hash_tb.sv
`timescale 1ns / 100ps

module murmur3_32_stream_hash_tb;

	localparam int DIR_N        = 17;
	localparam int PHASES       = 5;
	localparam int PHASE_ITEMS  = 270;
	localparam int DRAIN_CYCLES = 16;
	localparam int LIMIT_CYCLES = 400000;

	// One row of the directed table: a key word, and where the hash can be
	// read off by eye, the hash that the key must give
	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  count;
		logic        last;
		logic        pinned;
		logic [31:0] hash;
	} vec_t;

	// All rows run under the reset seed of zero
	vec_t dir_vecs [0:DIR_N-1] = '{
		// empty key: nothing mixed, zero length, so zero finalises to zero
		'{32'h0000_0000, 3'd0, 1'b1, 1'b1, 32'h0000_0000},
		// one zero byte: only the length of one survives into the finalisation
		'{32'h0000_0000, 3'd1, 1'b1, 1'b1, 32'h514e_28b7},
		// all-ones last words of lengths one to four, bytes above the count masked off
		'{32'hffff_ffff, 3'd4, 1'b1, 1'b0, 32'h0},
		'{32'hffff_ffff, 3'd3, 1'b1, 1'b0, 32'h0},
		'{32'hffff_ffff, 3'd2, 1'b1, 1'b0, 32'h0},
		'{32'hffff_ffff, 3'd1, 1'b1, 1'b0, 32'h0},
		// count above four on a last word counts as four
		'{32'h1234_5678, 3'd7, 1'b1, 1'b0, 32'h0},
		'{32'ha5a5_a5a5, 3'd5, 1'b1, 1'b0, 32'h0},
		// multi-word key with short and oversized counts on words not marked last
		'{32'hdead_beef, 3'd4, 1'b0, 1'b0, 32'h0},
		'{32'hcafe_babe, 3'd2, 1'b0, 1'b0, 32'h0},
		'{32'h0123_4567, 3'd0, 1'b0, 1'b0, 32'h0},
		'{32'h89ab_cdef, 3'd6, 1'b0, 1'b0, 32'h0},
		'{32'hfedc_ba98, 3'd3, 1'b1, 1'b0, 32'h0},
		// full word followed by an empty last word
		'{32'h0000_0000, 3'd4, 1'b0, 1'b0, 32'h0},
		'{32'hffff_ffff, 3'd0, 1'b1, 1'b0, 32'h0},
		// two full words, the second one last
		'{32'h8000_0001, 3'd4, 1'b0, 1'b0, 32'h0},
		'{32'h7fff_fffe, 3'd4, 1'b1, 1'b0, 32'h0}
	};

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        hash_seed_we = 1'b0;
	logic [31:0] hash_seed    = 32'h0;
	logic        key_valid    = 1'b0;
	logic        key_stall;
	logic [31:0] key_word     = 32'h0;
	logic [2:0]  byte_count   = 3'd0;
	logic        last_word    = 1'b0;
	logic        hash_valid;
	logic        hash_stall   = 1'b0;
	logic [31:0] hash_value;

	// Model of the hash engine: seed register, running hash and length of
	// the key in progress
	logic [31:0] seed_model      = 32'h0;
	logic [31:0] acc_hash        = 32'h0;
	logic [31:0] acc_len         = 32'h0;
	logic        key_in_progress = 1'b0;

	logic [31:0] hash_due [$];
	logic [31:0] hash_want;
	int          mismatches  = 0;
	int          items_sent  = 0;
	int          cycle_count = 0;
	int unsigned stall_left  = 0;
	logic        gaps_on     = 1'b1;
	logic        stall_on    = 1'b1;

	murmur3_32_stream_hash DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.hash_seed_we (hash_seed_we),
		.hash_seed    (hash_seed),
		.key_valid    (key_valid),
		.key_stall    (key_stall),
		.key_word     (key_word),
		.byte_count   (byte_count),
		.last_word    (last_word),
		.hash_valid   (hash_valid),
		.hash_stall   (hash_stall),
		.hash_value   (hash_value)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [31:0] rotl32(logic [31:0] v, int unsigned s);
		return (v << s) | (v >> (32 - s));
	endfunction

	function automatic logic [31:0] scramble_word(logic [31:0] k);
		k = k * mm3_pkg::MIX_C1;
		k = rotl32(k, 15);
		k = k * mm3_pkg::MIX_C2;
		return k;
	endfunction

	function automatic logic [31:0] finalise_hash(logic [31:0] h);
		h = h ^ (h >> 16);
		h = h * mm3_pkg::FIN_M1;
		h = h ^ (h >> 13);
		h = h * mm3_pkg::FIN_M2;
		h = h ^ (h >> 16);
		return h;
	endfunction

	// Fold one accepted word into the model; flag and return the hash when
	// the word closes its key
	task automatic absorb_word(input logic [31:0] w, input logic [2:0] c, input logic l,
			output logic done, output logic [31:0] hv);
		logic [31:0] h;
		logic [31:0] len;
		logic [2:0]  n;
		logic [31:0] mask;
		// a fresh key starts from whatever seed is loaded now
		if (!key_in_progress) begin
			acc_hash = seed_model;
			acc_len  = 32'h0;
		end
		h   = acc_hash;
		len = acc_len;
		n   = (c > mm3_pkg::FULL_COUNT || !l) ? mm3_pkg::FULL_COUNT : c;
		if (n == mm3_pkg::FULL_COUNT) begin
			h = h ^ scramble_word(w);
			h = rotl32(h, 13);
			h = h * 32'd5 + mm3_pkg::FOLD_ADD;
		end else if (n != 3'd0) begin
			mask = (32'h1 << (8 * n)) - 32'h1;
			h    = h ^ scramble_word(w & mask);
		end
		len = len + 32'(n);
		done = l;
		hv   = 32'h0;
		if (l) begin
			hv              = finalise_hash(h ^ len);
			acc_hash        = seed_model;
			acc_len         = 32'h0;
			key_in_progress = 1'b0;
		end else begin
			acc_hash        = h;
			acc_len         = len;
			key_in_progress = 1'b1;
		end
	endtask

	// Offer one item, hold it until accepted, then queue its hash if it
	// closes a key. A pinned hash replaces the modelled one.
	task automatic put_word(input logic [31:0] w, input logic [2:0] c, input logic l,
			input logic pinned, input logic [31:0] pinned_hash);
		logic        done;
		logic [31:0] hv;
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			key_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		key_valid  <= 1'b1;
		key_word   <= w;
		byte_count <= c;
		last_word  <= l;
		@(posedge clk);
		while (key_stall) @(posedge clk);
		absorb_word(w, c, l, done, hv);
		if (done)
			hash_due.push_back(pinned ? pinned_hash : hv);
		items_sent++;
	endtask

	// Load a new seed once every key has come out and the pipeline is empty
	task automatic load_seed(input logic [31:0] s);
		key_valid <= 1'b0;
		while (hash_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		hash_seed_we <= 1'b1;
		hash_seed    <= s;
		@(posedge clk);
		hash_seed_we <= 1'b0;
		seed_model = s;
	endtask

	// One random key: a run of body words, mostly full, then a last word of
	// any count. Idling is switched per key so that quiet stretches appear.
	task automatic send_random_key(input logic idle_ok);
		int          body;
		int          i;
		logic [2:0]  c;
		gaps_on = idle_ok && $urandom_range(0, 3) != 0;
		stall_on <= idle_ok && $urandom_range(0, 3) != 0;
		body = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 9);
		for (i = 0; i < body; i++) begin
			// now and then a body word carries a short or oversized count
			c = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) :
				mm3_pkg::FULL_COUNT;
			put_word($urandom, c, 1'b0, 1'b0, 32'h0);
		end
		c = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
		put_word($urandom, c, 1'b1, 1'b0, 32'h0);
	endtask

	// Check each hash taken by the sink against the oldest one due, and
	// stall the sink in random bursts
	always @(posedge clk) begin
		if (arst_n && hash_valid && !hash_stall) begin
			if (hash_due.size() == 0) begin
				$display("%0t: hash_value expected none actual %08h", $time, hash_value);
				mismatches++;
			end else begin
				hash_want = hash_due.pop_front();
				if (hash_value !== hash_want) begin
					$display("%0t: hash_value expected %08h actual %08h",
						$time, hash_want, hash_value);
					mismatches++;
				end
			end
		end
		if (stall_left != 0)
			stall_left = stall_left - 1;
		else if (stall_on && $urandom_range(0, 4) == 0)
			stall_left = $urandom_range(1, 7);
		hash_stall <= (stall_left != 0);
	end

	// Drop the run if it hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("murmur3_32_stream_hash_tb failed");
			$finish;
		end
	end

	initial begin
		int          i;
		int          p;
		logic [31:0] s;
		// hold reset low from the start, then release it on an edge
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table under the reset seed
		for (i = 0; i < DIR_N; i++)
			put_word(dir_vecs[i].word, dir_vecs[i].count, dir_vecs[i].last,
				dir_vecs[i].pinned, dir_vecs[i].hash);

		// random keys, one seed per phase; the last phase runs without idling
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0:       s = 32'hffff_ffff;
				1:       s = 32'h0000_0000;
				3:       s = 32'h8000_0001;
				default: s = $urandom;
			endcase
			load_seed(s);
			while (items_sent < DIR_N + (p + 1) * PHASE_ITEMS)
				send_random_key(p != PHASES - 1);
		end

		// drain: wait for every outstanding hash, then a little longer
		key_valid <= 1'b0;
		stall_on  <= 1'b0;
		while (hash_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("murmur3_32_stream_hash_tb passed");
		else
			$display("murmur3_32_stream_hash_tb failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/mm3_pkg.sv
rtl/mm3_front.sv
rtl/mm3_queue.sv
rtl/mm3_back.sv
rtl/murmur3_32_stream_hash.sv
test/murmur3_32_stream_hash_tb.sv
